[src/hwmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmf_pkg
// Shared widths, register map and control types of the windowed-mean forecast
// block.
// ----------------------------------------------------------------------------
package hwmf_pkg;

  localparam int unsigned DATA_W      = 32;  // sample and mean width
  localparam int unsigned COEF_W      = 32;  // signed Q16.16 coefficient width
  localparam int unsigned FC_W        = 48;  // saturated forecast width
  localparam int unsigned FRAC_W      = 16;  // fraction bits of Q16.16
  localparam int unsigned LAG_W       = 6;   // lag register width
  localparam int unsigned NUM_LANES   = 3;   // short, mid, long
  localparam int unsigned MAX_LAG_DEF = 32;  // default ring depth

  localparam logic [LAG_W-1:0] LAG_SHORT_RST = 6'd1;
  localparam logic [LAG_W-1:0] LAG_MID_RST   = 6'd5;
  localparam logic [LAG_W-1:0] LAG_LONG_RST  = 6'd22;

  typedef enum logic [2:0] {
    REG_LAG_SHORT      = 3'd0,
    REG_LAG_MID        = 3'd1,
    REG_LAG_LONG       = 3'd2,
    REG_COEF_INTERCEPT = 3'd3,
    REG_COEF_SHORT     = 3'd4,
    REG_COEF_MID       = 3'd5,
    REG_COEF_LONG      = 3'd6
  } cfg_reg_e;

  // per-cycle commands to the multiply-accumulate unit
  typedef struct packed {
    logic load;  // accumulator takes the intercept
    logic mul;   // product register takes mean times coefficient
    logic acc;   // accumulator adds the product register
  } mac_ctrl_t;

endpackage

[src/hwmf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module hwmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/hwmf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmf_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// DATA_W bits, so the bits above DATA_W seed the partial remainder.
// ----------------------------------------------------------------------------
module hwmf_div import hwmf_pkg::*; #(
  parameter int unsigned SUM_W = 37,
  parameter int unsigned DIV_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic [DATA_W-1:0] quot_o,
  output logic              done_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DIV_W'(dividend_i[SUM_W-1:DATA_W]);
      dvs_d  = divisor_i;
      quo_d  = dividend_i[DATA_W-1:0];
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
      quo_d = {quo_q[DATA_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

  // partial remainder always stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

[src/hwmf_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwmf_mac
// Shared multiply-accumulate: mean times coefficient floored to Q16.16,
// summed with the intercept and saturated to the forecast width.
// ----------------------------------------------------------------------------
module hwmf_mac import hwmf_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [DATA_W-1:0]        mean_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic signed [COEF_W-1:0] icpt_i,
  output logic signed [FC_W-1:0]   forecast_o
);

  localparam int unsigned PROD_W = DATA_W + 1 + COEF_W;
  localparam int unsigned SHR_W  = PROD_W - FRAC_W;
  localparam int unsigned ACC_W  = SHR_W + 2;
  localparam logic signed [ACC_W-1:0] FC_MAX =
    {{(ACC_W - FC_W + 1){1'b0}}, {(FC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] FC_MIN = ~FC_MAX;

  logic signed [DATA_W:0]     mean_s;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [SHR_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  assign mean_s    = signed'({1'b0, mean_i});
  assign prod_full = mean_s * coef_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      // arithmetic drop of the fraction bits is a floor
      prod_q <= prod_full[PROD_W-1:FRAC_W];
    end
    if (ctrl_i.load) begin
      acc_q <= ACC_W'(icpt_i);
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_comb begin
    if (acc_q > FC_MAX) begin
      forecast_o = FC_MAX[FC_W-1:0];
    end else if (acc_q < FC_MIN) begin
      forecast_o = FC_MIN[FC_W-1:0];
    end else begin
      forecast_o = acc_q[FC_W-1:0];
    end
  end

endmodule

[src/har_window_mean_forecast_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// har_window_mean_forecast_core
// Windowed means of a realized measure over three lags and a one-step linear
// forecast from them.
//
// Input channel (in_valid_i/in_ready_o, sample_i) takes one sample word into a
// ring of MAX_LAG entries. Once as many samples as the longest lag are held,
// the output channel (out_valid_o/out_ready_i) gives one word: the three
// window means and the saturated forecast. Earlier samples give no word.
// Per sample that gives a word the core walks the ring once (one memory read
// per cycle), then runs one shared 32-step serial divider for each mean and
// one shared multiplier for the forecast; in_ready_o is low from the accept
// until the result is loaded into the output register. A sample that gives
// no word leaves in_ready_o high.
// The result sits in an output register; a new sample is taken while it waits,
// and the core holds its next result until the receiver takes the old one.
// Reset empties the ring (fill count zero), restores lags 1, 5, 22 and zero
// coefficients; no clearing pass is needed. The user must write registers
// via cfg_we_i/cfg_idx_i/cfg_data_i only while the core is idle, unchecked.
// ----------------------------------------------------------------------------
module har_window_mean_forecast_core import hwmf_pkg::*; #(
  parameter int unsigned MAX_LAG = MAX_LAG_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [DATA_W-1:0]        sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DATA_W-1:0]        mean_short_o,
  output logic [DATA_W-1:0]        mean_mid_o,
  output logic [DATA_W-1:0]        mean_long_o,
  output logic signed [FC_W-1:0]   forecast_o
);

  localparam int unsigned PTR_W = $clog2(MAX_LAG);
  localparam int unsigned CNT_W = $clog2(MAX_LAG + 1);
  localparam int unsigned SUM_W = DATA_W + PTR_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MAC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [LAG_W-1:0]         lag_q [NUM_LANES];
  logic signed [COEF_W-1:0] icpt_q;
  logic signed [COEF_W-1:0] wgt_q [NUM_LANES];

  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic [CNT_W-1:0]  rcv_q, rcv_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [SUM_W-1:0]  sum_q [NUM_LANES];
  logic [SUM_W-1:0]  sum_d [NUM_LANES];
  logic [DATA_W-1:0] mean_q [NUM_LANES];
  logic [DATA_W-1:0] mean_d [NUM_LANES];
  logic [1:0]        lane_q, lane_d;
  logic [1:0]        mstep_q, mstep_d;
  logic              launch_q, launch_d;
  logic              out_valid_q, out_valid_d;
  logic              out_load;

  logic [CNT_W-1:0]  eff_lag [NUM_LANES];
  logic [CNT_W-1:0]  longest;
  logic [CNT_W-1:0]  fill_new;
  logic [CNT_W-1:0]  rcv_next;
  logic [SUM_W-1:0]  acc_next;
  logic              in_acc;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] div_quot;
  logic              div_done;
  logic [1:0]        mac_lane;
  mac_ctrl_t         mac_ctrl;
  logic signed [FC_W-1:0] mac_forecast;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q[0] <= LAG_SHORT_RST;
      lag_q[1] <= LAG_MID_RST;
      lag_q[2] <= LAG_LONG_RST;
      icpt_q   <= '0;
      wgt_q[0] <= '0;
      wgt_q[1] <= '0;
      wgt_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LAG_SHORT:      lag_q[0] <= cfg_data_i[LAG_W-1:0];
        REG_LAG_MID:        lag_q[1] <= cfg_data_i[LAG_W-1:0];
        REG_LAG_LONG:       lag_q[2] <= cfg_data_i[LAG_W-1:0];
        REG_COEF_INTERCEPT: icpt_q   <= signed'(cfg_data_i);
        REG_COEF_SHORT:     wgt_q[0] <= signed'(cfg_data_i);
        REG_COEF_MID:       wgt_q[1] <= signed'(cfg_data_i);
        REG_COEF_LONG:      wgt_q[2] <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // zero lag acts as one, lags past the ring depth are clamped
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lag_q[i] == '0) begin
        eff_lag[i] = CNT_W'(1);
      end else if (32'(lag_q[i]) > 32'(MAX_LAG)) begin
        eff_lag[i] = CNT_W'(MAX_LAG);
      end else begin
        eff_lag[i] = CNT_W'(lag_q[i]);
      end
    end
    longest = eff_lag[0];
    for (int i = 1; i < NUM_LANES; i++) begin
      if (eff_lag[i] > longest) begin
        longest = eff_lag[i];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign fill_new   = (fill_q == CNT_W'(MAX_LAG)) ? fill_q : fill_q + 1'b1;
  assign rcv_next   = rcv_q + 1'b1;
  assign acc_next   = acc_q + SUM_W'(ram_rdata);
  assign mac_lane   = (mstep_q == 2'(NUM_LANES)) ? 2'(NUM_LANES - 1) : mstep_q;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    iss_d    = iss_q;
    rcv_d    = rcv_q;
    rd_vld_d = 1'b0;
    acc_d    = acc_q;
    sum_d    = sum_q;
    mean_d   = mean_q;
    lane_d   = lane_q;
    mstep_d  = mstep_q;
    launch_d = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    mac_ctrl = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d   = (wp_q == PTR_W'(MAX_LAG - 1)) ? '0 : wp_q + 1'b1;
          fill_d = fill_new;
          rp_d   = wp_q;  // newest sample first
          iss_d  = '0;
          rcv_d  = '0;
          acc_d  = '0;
          if (fill_new >= longest) begin
            state_d = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        if (iss_q != longest) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          iss_d    = iss_q + 1'b1;
          rp_d     = (rp_q == '0) ? PTR_W'(MAX_LAG - 1) : rp_q - 1'b1;
        end
        // windows nest, so each sum is a snapshot of one running total
        if (rd_vld_q) begin
          acc_d = acc_next;
          rcv_d = rcv_next;
          for (int i = 0; i < NUM_LANES; i++) begin
            if (rcv_next == eff_lag[i]) begin
              sum_d[i] = acc_next;
            end
          end
          if (rcv_next == longest) begin
            state_d  = ST_DIV;
            lane_d   = '0;
            launch_d = 1'b1;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          mean_d[lane_q] = div_quot;
          if (lane_q == 2'(NUM_LANES - 1)) begin
            state_d = ST_MAC;
            mstep_d = '0;
          end else begin
            lane_d   = lane_q + 1'b1;
            launch_d = 1'b1;
          end
        end
      end

      ST_MAC: begin
        mac_ctrl.load = (mstep_q == '0);
        mac_ctrl.mul  = (mstep_q != 2'(NUM_LANES));
        mac_ctrl.acc  = (mstep_q != '0);
        mstep_d       = mstep_q + 1'b1;
        if (mstep_q == 2'(NUM_LANES)) begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      rcv_q       <= '0;
      rd_vld_q    <= 1'b0;
      lane_q      <= '0;
      mstep_q     <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      rcv_q       <= rcv_d;
      rd_vld_q    <= rd_vld_d;
      lane_q      <= lane_d;
      mstep_q     <= mstep_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    mean_q <= mean_d;
    if (out_load) begin
      mean_short_o <= mean_q[0];
      mean_mid_o   <= mean_q[1];
      mean_long_o  <= mean_q[2];
      forecast_o   <= mac_forecast;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------- units
  hwmf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LAG)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  hwmf_div #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (launch_q),
    .dividend_i (sum_q[lane_q]),
    .divisor_i  (eff_lag[lane_q]),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  hwmf_mac u_mac (
    .clk_i      (clk_i),
    .ctrl_i     (mac_ctrl),
    .mean_i     (mean_q[mac_lane]),
    .coef_i     (wgt_q[mac_lane]),
    .icpt_i     (icpt_q),
    .forecast_o (mac_forecast)
  );

  // ---------------------------------------------------------------- checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_LAG))
    else $error("fill count above ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && rd_vld_q) |-> rcv_q < longest)
    else $error("ring walk read past the longest window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fill_new < longest) |=> state_q == ST_IDLE)
    else $error("short history started a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> state_q == ST_OUT)
    else $error("pending word overwritten");

endmodule

[verif/har_window_mean_forecast_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// har_window_mean_forecast_core_test
// Self-checking bench for the windowed-mean forecast core. A scoreboard keeps
// its own sample ring, lags and coefficients, works out the three means and
// the saturated forecast for every sample that gives a result word, and
// checks each result word in order. Stimulus runs a directed opening, then
// random phases with random and extreme register settings, random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module har_window_mean_forecast_core_test;
  import hwmf_pkg::*;

  localparam int unsigned RING_DEPTH    = MAX_LAG_DEF;
  localparam int unsigned SETTLE_CYCLES = 200;   // longest lag plus divider and multiply
  localparam int unsigned LONG_HOLD     = 2000;
  localparam int unsigned SEG_ITEMS     = 110;
  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  localparam longint      FC_HI         = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      FC_LO         = -FC_HI - 1;

  typedef struct packed {
    logic [DATA_W-1:0]      mean_short;
    logic [DATA_W-1:0]      mean_mid;
    logic [DATA_W-1:0]      mean_long;
    logic signed [FC_W-1:0] forecast;
  } forecast_word_t;

  class forecast_scoreboard;
    logic [DATA_W-1:0] ring [RING_DEPTH];
    logic [4:0]        wptr;
    int unsigned       fill;
    logic [LAG_W-1:0]  lag [NUM_LANES];
    logic [COEF_W-1:0] coef [4];   // intercept, short, mid, long
    forecast_word_t    expected_q [$];
    int unsigned       errors;

    function new();
      wptr    = '0;
      fill    = 0;
      errors  = 0;
      lag[0]  = LAG_SHORT_RST;
      lag[1]  = LAG_MID_RST;
      lag[2]  = LAG_LONG_RST;
      for (int i = 0; i < 4; i++) coef[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        REG_LAG_SHORT:      lag[0] = d[LAG_W-1:0];
        REG_LAG_MID:        lag[1] = d[LAG_W-1:0];
        REG_LAG_LONG:       lag[2] = d[LAG_W-1:0];
        REG_COEF_INTERCEPT: coef[0] = d;
        REG_COEF_SHORT:     coef[1] = d;
        REG_COEF_MID:       coef[2] = d;
        REG_COEF_LONG:      coef[3] = d;
        default: ;
      endcase
    endfunction

    function logic [LAG_W-1:0] eff_lag(logic [LAG_W-1:0] l);
      if (l == '0) return LAG_W'(1);
      if (32'(l) > RING_DEPTH) return LAG_W'(RING_DEPTH);
      return l;
    endfunction

    // unsigned mean times signed coefficient, floored back to q16.16
    function longint floor_product(logic [DATA_W-1:0] m, logic [COEF_W-1:0] c);
      longint p;
      p = longint'({32'd0, m}) * longint'($signed(c));
      return p >>> FRAC_W;
    endfunction

    function void note_sample(logic [DATA_W-1:0] s);
      logic [36:0]       sum;
      logic [LAG_W-1:0]  l;
      logic [LAG_W-1:0]  longest;
      logic [4:0]        idx;
      logic [DATA_W-1:0] mean [NUM_LANES];
      int unsigned       n;
      longint            acc;
      forecast_word_t    w;
      ring[wptr] = s;
      wptr = wptr + 5'd1;
      if (fill < RING_DEPTH) fill++;
      longest = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        l = eff_lag(lag[i]);
        n = (32'(l) < fill) ? 32'(l) : fill;
        sum = '0;
        for (int k = 0; k < n; k++) begin
          idx = wptr - 5'(k) - 5'd1;
          sum += 37'(ring[idx]);
        end
        mean[i] = 32'(sum / l);
        if (l > longest) longest = l;
      end
      if (fill < 32'(longest)) return;
      acc = longint'($signed(coef[0]));
      for (int i = 0; i < NUM_LANES; i++) acc += floor_product(mean[i], coef[i+1]);
      if (acc > FC_HI) acc = FC_HI;
      else if (acc < FC_LO) acc = FC_LO;
      w.mean_short = mean[0];
      w.mean_mid   = mean[1];
      w.mean_long  = mean[2];
      w.forecast   = acc[FC_W-1:0];
      expected_q.push_back(w);
    endfunction

    function void check_result(forecast_word_t got);
      forecast_word_t exp_w;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: forecast %h", got.forecast);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.mean_short !== exp_w.mean_short) begin
        $error("mean_short: expected %h, actual %h", exp_w.mean_short, got.mean_short);
        errors++;
      end
      if (got.mean_mid !== exp_w.mean_mid) begin
        $error("mean_mid: expected %h, actual %h", exp_w.mean_mid, got.mean_mid);
        errors++;
      end
      if (got.mean_long !== exp_w.mean_long) begin
        $error("mean_long: expected %h, actual %h", exp_w.mean_long, got.mean_long);
        errors++;
      end
      if (got.forecast !== exp_w.forecast) begin
        $error("forecast: expected %h, actual %h", exp_w.forecast, got.forecast);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [2:0]             cfg_idx   = '0;
  logic [DATA_W-1:0]      cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [DATA_W-1:0]      sample    = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_W-1:0]      mean_short;
  logic [DATA_W-1:0]      mean_mid;
  logic [DATA_W-1:0]      mean_long;
  logic signed [FC_W-1:0] forecast;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_armed  = 1'b0;
  logic        hold_taken  = 1'b0;
  int unsigned hold_left   = 0;

  forecast_scoreboard sb;

  har_window_mean_forecast_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .mean_short_o(mean_short),
    .mean_mid_o  (mean_mid),
    .mean_long_o (mean_long),
    .forecast_o  (forecast)
  );

  always #2 clk_i = ~clk_i;

  // receiver side, with a single long hold-off once armed
  always @(negedge clk_i) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    forecast_word_t got;
    if (rst_ni && sb != null) begin
      if (in_valid && in_ready) sb.note_sample(sample);
      if (out_valid && out_ready) begin
        got.mean_short = mean_short;
        got.mean_mid   = mean_mid;
        got.mean_long  = mean_long;
        got.forecast   = forecast;
        sb.check_result(got);
      end
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  // stop offering, wait for every expected word, then let the core go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_lag();
    logic [DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(2))
      0:       d[LAG_W-1:0] = LAG_W'($urandom_range(63));
      1:       d[LAG_W-1:0] = LAG_W'($urandom_range(1, 8));
      default: begin
        case ($urandom_range(3))
          0:       d[LAG_W-1:0] = 6'd0;
          1:       d[LAG_W-1:0] = 6'd1;
          2:       d[LAG_W-1:0] = 6'd32;
          default: d[LAG_W-1:0] = 6'd63;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [COEF_W-1:0] c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: begin
        c = $urandom_range(32'h0004_0000);
        if ($urandom_range(1)) c = -c;
      end
      2: c = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: c = '0;
    endcase
    return c;
  endfunction

  // mode 0: random, 1: shortest lags with top coefficients, 2: longest lags, bottom
  task automatic load_config(input int mode);
    logic [COEF_W-1:0] c;
    case (mode)
      1: begin
        write_reg(REG_LAG_SHORT, 32'd1);
        write_reg(REG_LAG_MID, 32'd1);
        write_reg(REG_LAG_LONG, 32'd1);
      end
      2: begin
        write_reg(REG_LAG_SHORT, 32'd63);
        write_reg(REG_LAG_MID, 32'd32);
        write_reg(REG_LAG_LONG, 32'd63);
      end
      default: begin
        write_reg(REG_LAG_SHORT, pick_lag());
        write_reg(REG_LAG_MID, pick_lag());
        write_reg(REG_LAG_LONG, pick_lag());
      end
    endcase
    for (int r = REG_COEF_INTERCEPT; r <= REG_COEF_LONG; r++) begin
      c = (mode == 1) ? 32'h7FFF_FFFF : (mode == 2) ? 32'h8000_0000 : pick_coef();
      write_reg(3'(r), c);
    end
  endtask

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // zero lag acts as one; saturation toward the top; unused index ignored
    write_reg(REG_LAG_SHORT, 32'd0);
    write_reg(REG_LAG_MID, 32'd2);
    write_reg(REG_LAG_LONG, 32'd3);
    write_reg(REG_COEF_INTERCEPT, 32'h7FFF_FFFF);
    write_reg(REG_COEF_SHORT, 32'h7FFF_FFFF);
    write_reg(REG_COEF_MID, 32'h7FFF_FFFF);
    write_reg(REG_COEF_LONG, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    tx_idle_pct = 7;
    rx_idle_pct = 62;
    repeat (4) send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h0001_0000);
    settle();

    // saturation toward the bottom
    for (int r = REG_COEF_INTERCEPT; r <= REG_COEF_LONG; r++) write_reg(3'(r), 32'h8000_0000);
    repeat (3) send_sample(32'hFFFF_FFFF);
    send_sample(32'h1234_5678);
    send_sample(32'h0000_0000);
    settle();

    // lag above the ring depth: no word until the ring fills
    write_reg(REG_LAG_SHORT, 32'd1);
    write_reg(REG_LAG_MID, 32'd32);
    write_reg(REG_LAG_LONG, 32'd63);
    write_reg(REG_COEF_INTERCEPT, 32'h0000_0000);
    write_reg(REG_COEF_SHORT, 32'h0001_0000);
    write_reg(REG_COEF_MID, 32'hFFFF_0000);
    write_reg(REG_COEF_LONG, 32'h0000_8000);
    repeat (6) send_sample(pick_sample());
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 62 : 0;
      rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 7 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        load_config((seg == 2 && phase < 2) ? phase + 1 : 0);
        if (phase == 2 && seg == 0) hold_armed = 1'b1;
        for (int i = 0; i < SEG_ITEMS; i++) send_sample(pick_sample());
        settle();
      end
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[har_window_mean_forecast_core.f]
src/hwmf_pkg.sv
src/hwmf_ram.sv
src/hwmf_div.sv
src/hwmf_mac.sv
src/har_window_mean_forecast_core.sv
verif/har_window_mean_forecast_core_test.sv
